// ===== design/htd_pkg.sv =====
// ----------------------------------------------------------------------------
// htd_pkg: shared types and constants for the Huffman tree decoder
// Node entry layout, command and status codes, step and result records.
// ----------------------------------------------------------------------------
package htd_pkg;

   // default sizes
   localparam int SYMBOL_COUNT    = 256;
   localparam int NODE_COUNT      = 512;
   localparam int MAX_CODE_LENGTH = 32;

   localparam int IDX_W   = 9;   // node index field width
   localparam int COUNT_W = 10;  // node count compare width
   localparam int SYM_W   = 8;
   localparam int CODE_W  = 32;
   localparam int CODE_IW = 5;   // bit index into code word
   localparam int LEN_W   = 6;
   localparam int ENTRY_W = 27;

   // commands
   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_LOAD   = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;

   // result status
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_DUP      = 3'd2;
   localparam logic [2:0] ST_CONFLICT = 3'd3;
   localparam logic [2:0] ST_MISSING  = 3'd4;

   typedef struct packed {
      logic               leaf;
      logic [SYM_W-1:0]   symbol;
      logic [IDX_W-1:0]   right;
      logic [IDX_W-1:0]   left;
   } entry_type;

   typedef struct packed {
      logic [IDX_W-1:0]   child;
      logic               child_ok;
      logic               leaf;
      logic [SYM_W-1:0]   symbol;
   } step_type;

   typedef struct packed {
      logic [SYM_W-1:0]   symbol;
      logic               valid;
      logic [2:0]         status;
   } result_type;

   typedef struct packed {
      logic               push;
      logic               finish;
   } out_ctl_type;

   typedef struct packed {
      logic               can_push;
      logic               out_free;
   } out_sts_type;

endpackage

// ===== design/htd_ram.sv =====
// ----------------------------------------------------------------------------
// htd_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module htd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/htd_step.sv =====
// ----------------------------------------------------------------------------
// htd_step: tree step unit
// Picks one child of a node entry and checks that it is an allocated node.
// ----------------------------------------------------------------------------
module htd_step #(
   parameter int NODE_COUNT = htd_pkg::NODE_COUNT
) (
   input  htd_pkg::entry_type               entry,
   input  logic                             branch,
   input  logic [htd_pkg::COUNT_W-1:0]      nodes_used,
   output htd_pkg::step_type                step
);

   logic [htd_pkg::IDX_W-1:0]   child;
   logic [htd_pkg::COUNT_W-1:0] child_ext;

   assign child     = branch ? entry.right : entry.left;
   assign child_ext = htd_pkg::COUNT_W'(child);

   always_comb begin
      step.child    = child;
      // root is never a child; index must be live
      step.child_ok = (child != '0) && (child_ext < nodes_used)
                      && (child_ext < htd_pkg::COUNT_W'(NODE_COUNT));
      step.leaf     = entry.leaf;
      step.symbol   = entry.symbol;
   end

endmodule

// ===== design/htd_out.sv =====
// ----------------------------------------------------------------------------
// htd_out: result holding stage
// Keeps the newest result pending until it is known whether it is the last
// one of its item, then moves it into the output register.
// ----------------------------------------------------------------------------
module htd_out (
   input  logic                  clock,
   input  logic                  reset,
   input  htd_pkg::out_ctl_type  ctl,
   input  htd_pkg::result_type   res,
   output htd_pkg::out_sts_type  sts,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,  // [7:0] decoded_symbol, [10:8] status
   output logic                  rsp_tuser,  // [0] symbol_valid
   output logic                  rsp_tlast
);

   logic                pend_valid_ff, pend_valid_in;
   htd_pkg::result_type pend_ff, pend_in;
   logic                rsp_valid_ff, rsp_valid_in;
   htd_pkg::result_type rsp_res_ff, rsp_res_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                out_free;

   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign sts.out_free = out_free;
   assign sts.can_push = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_res_in    = rsp_res_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.push) begin
         pend_valid_in = 1'b1;
         pend_in       = res;
         if (pend_valid_ff) begin
            rsp_valid_in = 1'b1;
            rsp_res_in   = pend_ff;
            rsp_last_in  = 1'b0;
         end
      end else if (ctl.finish) begin
         pend_valid_in = 1'b0;
         rsp_valid_in  = 1'b1;
         rsp_res_in    = pend_ff;
         rsp_last_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      pend_ff     <= pend_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_res_ff.status, rsp_res_ff.symbol};
   assign rsp_tuser  = rsp_res_ff.valid;
   assign rsp_tlast  = rsp_last_ff;

   // sequencer must only close an item that has a pending word
   a_finish_pend: assert property (@(posedge clock) disable iff (reset)
      ctl.finish |-> (pend_valid_ff && out_free))
      else $error("finish without pending word or free output");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> (!pend_valid_ff || out_free))
      else $error("push would overwrite a pending word");

   a_no_both: assert property (@(posedge clock) disable iff (reset)
      !(ctl.push && ctl.finish))
      else $error("push and finish in one cycle");

endmodule

// ===== design/huffman_tree_decoder.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder: Huffman code tree builder and bit-serial decoder
// Builds a binary code tree in a node RAM and walks it one bit per step.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel: one word per command. tuser carries the command (clear,
//  load one code entry, decode one byte); tdata carries the entry fields and
//  the compressed byte. req_tready is high only while the sequencer is idle.
//  rsp_ channel: one or more words per command, tlast on the final one.
//  Clear, load and unused commands give one word; a decode gives one word
//  per symbol found or branch missing (up to eight), or a single empty word.
// Steps (no stall): one node RAM read per tree step.
//  Decode: dispatch, one step per byte bit, a root read after each leaf, a
//  final check and close; the check is skipped when the last bit lands on a leaf.
//  Load: dispatch, a walk over existing nodes, a link, one write per new node
//  and the leaf write, then close; a conflict or full table ends the walk,
//  a duplicate ends it at the root, a bad length or symbol closes at once.
//  Clear: dispatch, the clearing pass, then close. Unused command: dispatch, close.
// Reset: a clearing pass over every symbol zeroes the symbol-seen RAM
//  and writes the root entry; req_tready stays low until it ends. A clear
//  command runs the same pass.
// Stall: results wait in a pending stage and an output register; the walk
//  pauses when both are full and resumes when rsp_tready returns.
// ----------------------------------------------------------------------------
module huffman_tree_decoder #(
   parameter int SYMBOL_COUNT    = htd_pkg::SYMBOL_COUNT,
   parameter int NODE_COUNT      = htd_pkg::NODE_COUNT,
   parameter int MAX_CODE_LENGTH = htd_pkg::MAX_CODE_LENGTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [7:0] load_symbol, [39:8] code_bits, [45:40] code_length,
   // [53:46] compressed_byte, [55:54] zero
   input  logic [55:0] req_tdata,
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] decoded_symbol, [10:8] status
   output logic        rsp_tuser,   // [0] symbol_valid
   output logic        rsp_tlast
);

   localparam int AW  = $clog2(NODE_COUNT);
   localparam int NUW = $clog2(NODE_COUNT + 1);
   localparam int SW  = $clog2(SYMBOL_COUNT);
   localparam int RW  = $clog2(MAX_CODE_LENGTH + 1);

   typedef enum logic [7:0] {
      S_INIT  = 8'b00000001,
      S_WIPE  = 8'b00000010,
      S_IDLE  = 8'b00000100,
      S_DEC   = 8'b00001000,
      S_WALK  = 8'b00010000,
      S_LINK  = 8'b00100000,
      S_ALLOC = 8'b01000000,
      S_DONE  = 8'b10000000
   } state_type;

   // input fields
   logic [htd_pkg::SYM_W-1:0]  in_sym;
   logic [htd_pkg::CODE_W-1:0] in_code;
   logic [htd_pkg::LEN_W-1:0]  in_len;
   logic [7:0]                 in_byte;

   assign in_sym  = req_tdata[7:0];
   assign in_code = req_tdata[39:8];
   assign in_len  = req_tdata[45:40];
   assign in_byte = req_tdata[53:46];

   // state
   state_type                  state_ff, state_in;
   logic [htd_pkg::IDX_W-1:0]  pos_ff, pos_in;       // decode walk position
   logic [NUW-1:0]             nu_ff, nu_in;         // nodes used
   logic [SW-1:0]              wipe_ff, wipe_in;     // clearing pass address
   logic [htd_pkg::SYM_W-1:0]  sym_ff, sym_in;
   logic [htd_pkg::CODE_W-1:0] code_ff, code_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [RW-1:0]              rem_ff, rem_in;       // code bits not walked
   logic [3:0]                 bleft_ff, bleft_in;   // byte bits not walked
   logic [htd_pkg::IDX_W-1:0]  node_ff, node_in;     // load walk node
   logic                       emitted_ff, emitted_in;

   // node RAM port
   logic                       wr_en, rd_en;
   logic [AW-1:0]              wr_addr, rd_addr;
   htd_pkg::entry_type         wr_entry, rd_entry;

   // symbol-seen RAM port
   logic                       seen_wr_en, seen_wr_data, seen_rd_en;
   logic [SW-1:0]              seen_wr_addr, seen_rd_addr;
   logic                       seen_rd;

   // step unit
   logic                       step_bit, code_bit, byte_bit;
   htd_pkg::step_type          step;
   logic [RW-1:0]              rem_m1;
   logic [3:0]                 bleft_m1;

   // output stage
   htd_pkg::out_ctl_type       out_ctl;
   htd_pkg::out_sts_type       out_sts;
   htd_pkg::result_type        res;

   logic                       req_fire;
   logic                       load_bad;
   logic [10:0]                alloc_end;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign rem_m1   = rem_ff - 1'b1;
   assign bleft_m1 = bleft_ff - 4'd1;
   assign code_bit = code_ff[htd_pkg::CODE_IW'(rem_m1)];
   assign byte_bit = byte_ff[3'(bleft_m1)];
   assign step_bit = (state_ff == S_DEC) ? byte_bit : code_bit;

   assign load_bad  = (in_len == '0)
                      || (in_len > htd_pkg::LEN_W'(MAX_CODE_LENGTH))
                      || (9'(in_sym) >= 9'(SYMBOL_COUNT));
   assign alloc_end = 11'(nu_ff) + 11'(rem_ff);

   htd_ram #(
      .WIDTH (htd_pkg::ENTRY_W),
      .DEPTH (NODE_COUNT)
   ) u_nodes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   htd_ram #(
      .WIDTH (1),
      .DEPTH (SYMBOL_COUNT)
   ) u_seen (
      .clock   (clock),
      .wr_en   (seen_wr_en),
      .wr_addr (seen_wr_addr),
      .wr_data (seen_wr_data),
      .rd_en   (seen_rd_en),
      .rd_addr (seen_rd_addr),
      .rd_data (seen_rd)
   );

   htd_step #(
      .NODE_COUNT (NODE_COUNT)
   ) u_step (
      .entry      (rd_entry),
      .branch     (step_bit),
      .nodes_used (htd_pkg::COUNT_W'(nu_ff)),
      .step       (step)
   );

   htd_out u_out (
      .clock      (clock),
      .reset      (reset),
      .ctl        (out_ctl),
      .res        (res),
      .sts        (out_sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      nu_in        = nu_ff;
      wipe_in      = wipe_ff;
      sym_in       = sym_ff;
      code_in      = code_ff;
      byte_in      = byte_ff;
      rem_in       = rem_ff;
      bleft_in     = bleft_ff;
      node_in      = node_ff;
      emitted_in   = emitted_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_entry     = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      seen_wr_en   = 1'b0;
      seen_wr_addr = '0;
      seen_wr_data = 1'b0;
      seen_rd_en   = 1'b0;
      seen_rd_addr = '0;
      out_ctl      = '0;
      res          = '0;
      res.status   = htd_pkg::ST_OK;

      case (state_ff)
         // one seen flag per cycle; root entry (no children) rewritten alongside
         S_INIT, S_WIPE: begin
            wr_en        = 1'b1;
            seen_wr_en   = 1'b1;
            seen_wr_addr = wipe_ff;
            wipe_in      = wipe_ff + 1'b1;
            if (wipe_ff == SW'(SYMBOL_COUNT - 1)) begin
               wipe_in  = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end

         S_IDLE: begin
            if (req_tvalid) begin
               case (req_tuser)
                  htd_pkg::CMD_CLEAR: begin
                     wr_en        = 1'b1;
                     nu_in        = NUW'(1);
                     pos_in       = '0;
                     wipe_in      = '0;
                     out_ctl.push = 1'b1;
                     state_in     = S_WIPE;
                  end
                  htd_pkg::CMD_LOAD: begin
                     if (load_bad) begin
                        res.status   = htd_pkg::ST_CONFLICT;
                        out_ctl.push = 1'b1;
                        state_in     = S_DONE;
                     end else begin
                        rd_en        = 1'b1;
                        seen_rd_en   = 1'b1;
                        seen_rd_addr = in_sym[SW-1:0];
                        node_in      = '0;
                        rem_in       = RW'(in_len);
                        sym_in       = in_sym;
                        code_in      = in_code;
                        state_in     = S_WALK;
                     end
                  end
                  htd_pkg::CMD_DECODE: begin
                     rd_en      = 1'b1;
                     rd_addr    = AW'(pos_ff);
                     byte_in    = in_byte;
                     bleft_in   = 4'd8;
                     emitted_in = 1'b0;
                     state_in   = S_DEC;
                  end
                  default: begin
                     out_ctl.push = 1'b1;
                     state_in     = S_DONE;
                  end
               endcase
            end
         end

         // rd_entry holds the node at pos_ff
         S_DEC: begin
            if (step.leaf) begin
               res.symbol = step.symbol;
               res.valid  = 1'b1;
               if (out_sts.can_push) begin
                  out_ctl.push = 1'b1;
                  emitted_in   = 1'b1;
                  pos_in       = '0;
                  rd_en        = 1'b1;
                  if (bleft_ff == '0) begin
                     state_in = S_DONE;
                  end
               end
            end else if (bleft_ff == '0) begin
               // no result from this byte: one empty word
               if (!emitted_ff) begin
                  out_ctl.push = 1'b1;
               end
               state_in = S_DONE;
            end else if (!step.child_ok) begin
               res.status = htd_pkg::ST_MISSING;
               if (out_sts.can_push) begin
                  out_ctl.push = 1'b1;
                  emitted_in   = 1'b1;
                  pos_in       = '0;
                  bleft_in     = bleft_m1;
                  rd_en        = 1'b1;
               end
            end else begin
               pos_in   = step.child;
               bleft_in = bleft_m1;
               rd_en    = 1'b1;
               rd_addr  = AW'(step.child);
            end
         end

         // rd_entry holds the node at node_ff; node_ff is the root only on
         // the first step, when seen_rd holds the flag of the new symbol
         S_WALK: begin
            if ((node_ff == '0) && seen_rd) begin
               res.status   = htd_pkg::ST_DUP;
               out_ctl.push = 1'b1;
               state_in     = S_DONE;
            end else if (step.leaf || (rem_ff == '0)) begin
               // path hits a leaf, or ends on an existing node
               res.status   = htd_pkg::ST_CONFLICT;
               out_ctl.push = 1'b1;
               state_in     = S_DONE;
            end else if (!step.child_ok) begin
               if (alloc_end > 11'(NODE_COUNT)) begin
                  res.status   = htd_pkg::ST_FULL;
                  out_ctl.push = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_LINK;
               end
            end else begin
               node_in = step.child;
               rem_in  = rem_m1;
               rd_en   = 1'b1;
               rd_addr = AW'(step.child);
            end
         end

         // hang the first new node under the last existing one
         S_LINK: begin
            wr_en    = 1'b1;
            wr_addr  = AW'(node_ff);
            wr_entry = rd_entry;
            if (code_bit) begin
               wr_entry.right = htd_pkg::IDX_W'(nu_ff);
            end else begin
               wr_entry.left = htd_pkg::IDX_W'(nu_ff);
            end
            rem_in   = rem_m1;
            state_in = S_ALLOC;
         end

         S_ALLOC: begin
            if (rem_ff == '0) begin
               if (out_sts.can_push) begin
                  wr_en           = 1'b1;
                  wr_addr         = AW'(nu_ff);
                  wr_entry.leaf   = 1'b1;
                  wr_entry.symbol = sym_ff;
                  seen_wr_en      = 1'b1;
                  seen_wr_addr    = sym_ff[SW-1:0];
                  seen_wr_data    = 1'b1;
                  nu_in           = nu_ff + 1'b1;
                  out_ctl.push    = 1'b1;
                  state_in        = S_DONE;
               end
            end else begin
               wr_en   = 1'b1;
               wr_addr = AW'(nu_ff);
               if (code_bit) begin
                  wr_entry.right = htd_pkg::IDX_W'(nu_ff + 1'b1);
               end else begin
                  wr_entry.left = htd_pkg::IDX_W'(nu_ff + 1'b1);
               end
               nu_in  = nu_ff + 1'b1;
               rem_in = rem_m1;
            end
         end

         // pending word becomes the last of this item
         S_DONE: begin
            if (out_sts.out_free) begin
               out_ctl.finish = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_INIT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_INIT;
         pos_ff     <= '0;
         nu_ff      <= NUW'(1);
         wipe_ff    <= '0;
         emitted_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         pos_ff     <= pos_in;
         nu_ff      <= nu_in;
         wipe_ff    <= wipe_in;
         emitted_ff <= emitted_in;
      end
      sym_ff   <= sym_in;
      code_ff  <= code_in;
      byte_ff  <= byte_in;
      rem_ff   <= rem_in;
      bleft_ff <= bleft_in;
      node_ff  <= node_in;
   end

   a_nodes_range: assert property (@(posedge clock) disable iff (reset)
      (nu_ff != '0) && (nu_ff <= NUW'(NODE_COUNT)))
      else $error("node count out of range");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_tuser == htd_pkg::CMD_CLEAR))
      |=> ((nu_ff == NUW'(1)) && (pos_ff == '0) && (wipe_ff == '0)
           && (state_ff == S_WIPE)))
      else $error("clear left tree state behind");

   a_pos_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (htd_pkg::COUNT_W'(pos_ff) < htd_pkg::COUNT_W'(nu_ff)))
      else $error("walk position points past allocated nodes");

endmodule

// ===== tb/huffman_tree_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// huffman_tree_decoder_tb: self-checking bench for the Huffman tree decoder
// Drives clear, load, decode and unused command words with random gaps and
// a stalling receiver, predicts every result word from its own model of the
// tree, and checks each one in order. Ends with a single pass or fail line.
// ----------------------------------------------------------------------------
module huffman_tree_decoder_tb;

   // unused command code, answered with a plain ok word
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   localparam int TOTAL_ITEMS    = 200;   // request words after which the random loop stops
   localparam int RSP_HOLD       = 300;   // long receiver hold-off, cycles
   localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake at all
   localparam int TAIL_CYCLES    = 100;   // quiet time after the last word

   // one expected result word
   typedef struct {
      logic [htd_pkg::SYM_W-1:0] symbol;
      logic                      valid;
      logic                      last;
      logic [2:0]                status;
   } rsp_word_type;

   // -------------------------------------------------------------------------
   // Tree model and ordered store of expected result words
   // -------------------------------------------------------------------------
   class tree_scoreboard;
      htd_pkg::entry_type node_tbl [htd_pkg::NODE_COUNT];
      int unsigned        nodes_used;
      bit                 symbol_seen [htd_pkg::SYMBOL_COUNT];
      int unsigned        walk_pos;
      rsp_word_type       pending_words [$];
      int                 errors;

      function new();
         errors = 0;
         clear_tree();
      endfunction

      function void clear_tree();
         foreach (node_tbl[i]) node_tbl[i] = '0;
         foreach (symbol_seen[i]) symbol_seen[i] = 1'b0;
         nodes_used = 1;
         walk_pos   = 0;
      endfunction

      // append one expected word at the tail
      function void add_word(rsp_word_type w);
         pending_words = {pending_words, w};
      endfunction

      // child index, 0 when that branch was never allocated
      function int unsigned child_of(int unsigned node, bit dir);
         int unsigned c;
         c = dir ? node_tbl[node].right : node_tbl[node].left;
         if (c >= nodes_used) c = 0;
         return c;
      endfunction

      // insert one code; the tree is only touched once every check passed
      function logic [2:0] load_code(logic [7:0] sym, logic [31:0] bits, logic [5:0] len);
         int          n, i, need;
         int unsigned node, c;
         bit          fresh, dir;
         n = len;
         if (n == 0 || n > htd_pkg::MAX_CODE_LENGTH) return htd_pkg::ST_CONFLICT;
         if (symbol_seen[sym]) return htd_pkg::ST_DUP;
         node  = 0;
         need  = 0;
         fresh = 1'b0;
         for (i = 0; i < n; i++) begin
            dir = bits[n-1-i];
            c = child_of(node, dir);
            if (c == 0) begin
               need  = n - i;
               fresh = 1'b1;
               break;
            end
            // runs into a shorter code
            if (node_tbl[c].leaf) return htd_pkg::ST_CONFLICT;
            node = c;
         end
         if (!fresh) return htd_pkg::ST_CONFLICT;      // a longer code passes here
         if (nodes_used + need > htd_pkg::NODE_COUNT) return htd_pkg::ST_FULL;
         node = 0;
         for (i = 0; i < n; i++) begin
            dir = bits[n-1-i];
            c = child_of(node, dir);
            if (c == 0) begin
               c = nodes_used;
               node_tbl[c] = '0;
               nodes_used++;
               if (dir) node_tbl[node].right = htd_pkg::IDX_W'(c);
               else node_tbl[node].left = htd_pkg::IDX_W'(c);
            end
            node = c;
         end
         node_tbl[node] = '0;
         node_tbl[node].leaf = 1'b1;
         node_tbl[node].symbol = sym;
         symbol_seen[sym] = 1'b1;
         return htd_pkg::ST_OK;
      endfunction

      // accepted request word: update the tree and queue its result words
      function void note_request(logic [1:0] cmd, logic [55:0] data);
         rsp_word_type w;
         int unsigned  pos, c;
         int           i;
         bit           found;
         w = '{8'h00, 1'b0, 1'b1, htd_pkg::ST_OK};
         case (cmd)
            htd_pkg::CMD_CLEAR: begin
               clear_tree();
               add_word(w);
            end
            htd_pkg::CMD_LOAD: begin
               w.status = load_code(data[7:0], data[39:8], data[45:40]);
               add_word(w);
            end
            htd_pkg::CMD_DECODE: begin
               pos   = walk_pos;
               found = 1'b0;
               // compressed byte sits at [53:46], msb walked first
               for (i = 7; i >= 0; i--) begin
                  c = child_of(pos, data[46+i]);
                  w = '{8'h00, 1'b0, 1'b0, htd_pkg::ST_OK};
                  if (c == 0) begin
                     w.status = htd_pkg::ST_MISSING;
                     add_word(w);
                     found = 1'b1;
                     pos = 0;
                  end else if (node_tbl[c].leaf) begin
                     w.symbol = node_tbl[c].symbol;
                     w.valid  = 1'b1;
                     add_word(w);
                     found = 1'b1;
                     pos = 0;
                  end else begin
                     pos = c;
                  end
               end
               walk_pos = pos;
               if (!found) add_word('{8'h00, 1'b0, 1'b0, htd_pkg::ST_OK});
               pending_words[pending_words.size() - 1].last = 1'b1;
            end
            default: add_word(w);
         endcase
      endfunction

      function void check_response(logic [7:0] sym, logic valid, logic last,
                                   logic [2:0] status);
         rsp_word_type w;
         if (pending_words.size() == 0) begin
            if (errors < 10)
               $display("unexpected rsp word: sym %02h valid %0b last %0b status %0d",
                        sym, valid, last, status);
            errors++;
            return;
         end
         w = pending_words.pop_front();
         if (w.symbol !== sym || w.valid !== valid || w.last !== last ||
             w.status !== status) begin
            if (errors < 10)
               $display("rsp mismatch: exp sym %02h valid %0b last %0b status %0d, %s",
                        w.symbol, w.valid, w.last, w.status,
                        $sformatf("got sym %02h valid %0b last %0b status %0d",
                                  sym, valid, last, status));
            errors++;
         end
      endfunction

      function void report_leftover();
         if (pending_words.size() != 0) begin
            if (errors < 10)
               $display("%0d rsp words never arrived", pending_words.size());
            errors++;
         end
      endfunction

      function int pending();
         return pending_words.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset, block under test
   // -------------------------------------------------------------------------
   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = htd_pkg::CMD_CLEAR;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;

   always #5 clock = ~clock;

   huffman_tree_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   tree_scoreboard sb;
   int             items_sent   = 0;
   int             idle_cycles  = 0;
   bit             send_calm    = 1'b0;  // sender runs without gaps
   bit             hold_rsp_req = 1'b0;  // sender asks the receiver for a long hold

   // code table under construction: bits, length, symbol per entry
   logic [31:0] code_bits_q [$];
   int          code_len_q [$];
   logic [7:0]  code_sym_q [$];

   // -------------------------------------------------------------------------
   // Monitor and watchdog. Values are read right after the edge, before the
   // block's nonblocking updates land, so they are the values the edge saw.
   // Results are checked before the request of the same edge is noted; a
   // result can never belong to a request accepted at that very edge.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[7:0], rsp_tuser, rsp_tlast, rsp_tdata[10:8]);
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata);
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Receiver: a random stall before each word, calm stretches with no stall,
   // and one long hold-off on request from the sender side.
   // -------------------------------------------------------------------------
   initial begin : rsp_side
      int stall;
      int taken;
      bit calm;
      taken = 0;
      calm  = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD) @(posedge clock);
         end
         stall = calm ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         taken++;
         if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Sender tasks
   // -------------------------------------------------------------------------
   // one request word; returns at the edge that accepted it
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] sym,
                            input logic [31:0] bits, input logic [5:0] len,
                            input logic [7:0] packed_in);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {2'b00, packed_in, len, bits, sym};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_clear();
      send_word(htd_pkg::CMD_CLEAR, 8'($urandom), $urandom, 6'($urandom), 8'($urandom));
   endtask

   task automatic send_load(input logic [7:0] sym, input logic [31:0] bits,
                            input logic [5:0] len);
      send_word(htd_pkg::CMD_LOAD, sym, bits, len, 8'($urandom));
   endtask

   task automatic send_decode(input logic [7:0] packed_in);
      send_word(htd_pkg::CMD_DECODE, 8'($urandom), $urandom, 6'($urandom), packed_in);
   endtask

   // stop offering and wait until every expected word has come back
   task automatic drain_words();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   // complete prefix code: split random leaves until the target count (or the
   // try limit), then give every entry a distinct random symbol
   task automatic make_code(input int leaves, input int max_len);
      int         pick, tries;
      bit         used [256];
      logic [7:0] s;
      code_bits_q = '{32'd0};
      code_len_q  = '{0};
      code_sym_q.delete();
      tries = 0;
      while (code_len_q.size() < leaves && tries < 400) begin
         tries++;
         pick = $urandom_range(0, code_len_q.size() - 1);
         if (code_len_q[pick] < max_len) begin
            code_bits_q = {code_bits_q, (code_bits_q[pick] << 1) | 32'd1};
            code_len_q  = {code_len_q, code_len_q[pick] + 1};
            code_bits_q[pick] = code_bits_q[pick] << 1;
            code_len_q[pick]  = code_len_q[pick] + 1;
         end
      end
      foreach (used[i]) used[i] = 1'b0;
      foreach (code_len_q[i]) begin
         do s = 8'($urandom_range(0, 255)); while (used[s]);
         used[s] = 1'b1;
         code_sym_q = {code_sym_q, s};
      end
   endtask

   // load a code table (all of it, or only part for missing branches),
   // with the odd duplicate symbol thrown in, then decode random bytes
   task automatic run_tree_seq(input bit partial, input bit fresh);
      int max_len;
      max_len = ($urandom_range(0, 9) == 0) ? htd_pkg::MAX_CODE_LENGTH
                                            : $urandom_range(2, 10);
      make_code($urandom_range(2, 24), max_len);
      if (fresh) send_clear();
      foreach (code_len_q[i]) begin
         if (partial && $urandom_range(0, 2) == 0) continue;
         send_load(code_sym_q[i], code_bits_q[i], 6'(code_len_q[i]));
         if ($urandom_range(0, 15) == 0)
            send_load(code_sym_q[$urandom_range(0, i)], $urandom,
                      6'($urandom_range(1, 12)));
      end
      repeat ($urandom_range(3, 12)) send_decode(8'($urandom_range(0, 255)));
   endtask

   // long random codes until the node table runs out
   task automatic run_fill_seq();
      logic [7:0] base;
      base = 8'($urandom_range(0, 255));
      send_clear();
      for (int k = 0; k < 24; k++)
         send_load(base + k[7:0], $urandom, 6'(htd_pkg::MAX_CODE_LENGTH));
      repeat ($urandom_range(2, 6)) send_decode(8'($urandom_range(0, 255)));
   endtask

   // unstructured words: any command, any field value
   task automatic run_noise_seq();
      repeat ($urandom_range(3, 8))
         send_word(2'($urandom_range(0, 3)), 8'($urandom), $urandom,
                   6'($urandom_range(0, 63)), 8'($urandom));
   endtask

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int pick;
      sb = new();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: three-symbol code A=0, B=10, C=11
      send_calm = 1'b1;
      send_clear();
      send_decode(8'h00);                    // empty tree: eight missing branches
      send_load(8'h41, 32'h0, 6'd1);
      send_load(8'h42, 32'h2, 6'd2);
      send_load(8'h43, 32'h3, 6'd2);
      send_decode(8'hFF);                    // four C
      send_decode(8'h00);                    // eight A, the most words per byte
      send_decode(8'hA5);                    // B B A B, ends halfway down a code
      send_decode(8'h80);                    // finishes that code, then seven A
      send_load(8'h41, 32'h1, 6'd3);         // duplicate symbol
      send_load(8'h50, 32'h1, 6'd2);         // path runs into leaf A
      send_load(8'h51, 32'h1, 6'd1);         // ends on an inner node
      send_load(8'h52, 32'h0, 6'd0);         // empty code
      send_load(8'h53, 32'h0, 6'd33);        // one bit too long
      send_load(8'h54, 32'hFFFF_FFFF, 6'd63);
      send_word(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 8'hFF);
      // longest codes: a walk spread over three bytes, then a missing branch
      send_clear();
      send_load(8'hFF, 32'hFFFF_FFFF, 6'd32);
      send_decode(8'hFF);                    // no symbol yet, one empty word
      send_load(8'h00, 32'h0, 6'd32);        // load between bytes keeps the walk
      send_decode(8'hFF);
      send_decode(8'hFF);                    // still no symbol, one empty word
      send_decode(8'h7F);                    // missing 0, back to root, then seven 1
      drain_words();

      // receiver holds off while the sender keeps going, then a full drain
      send_calm = 1'b0;
      hold_rsp_req = 1'b1;
      run_tree_seq(1'b0, 1'b1);
      drain_words();
      run_fill_seq();
      drain_words();

      while (items_sent < TOTAL_ITEMS) begin
         send_calm = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 55) run_tree_seq(1'b0, $urandom_range(0, 4) != 0);
         else if (pick < 72) run_tree_seq(1'b1, 1'b1);
         else if (pick < 80) run_fill_seq();
         else run_noise_seq();
         if ($urandom_range(0, 2) == 0) drain_words();
      end

      drain_words();
      repeat (TAIL_CYCLES) @(posedge clock);
      sb.report_leftover();
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/htd_pkg.sv
design/htd_ram.sv
design/htd_step.sv
design/htd_out.sv
design/huffman_tree_decoder.sv
tb/huffman_tree_decoder_tb.sv
